// ===== hdl/nlqt_pkg.sv =====
// Shared types and constants for the neighbour link quality table.
`default_nettype none
package nlqt_pkg;

    localparam int NODE_W    = 16;
    localparam int Q_W       = 10;
    localparam int COUNT_W   = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [Q_W-1:0]     TOUCH_STEP_RESET = Q_W'(100);
    localparam logic [Q_W-1:0]     CEILING_RESET    = Q_W'(1000);
    localparam logic [COUNT_W-1:0] COUNT_MAX        = {COUNT_W{1'b1}};

    typedef enum logic [2:0] {
        CMD_TOUCH  = 3'd0,
        CMD_UPDATE = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_LOOKUP = 3'd3,
        CMD_COUNT  = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TOUCH_STEP = 1'b0,
        REG_CEILING    = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_INSERT
    } state_t;

    // Control from the sequencer to the head of the ring
    typedef struct packed {
        cmd_t cmd;
        logic insert_mode;
        logic count_all;
    } hd_ctrl_t;

    // Per-entry observations returned by the head
    typedef struct packed {
        logic match;
        logic free;
        logic count_hit;
        logic insert_hit;
    } hd_flags_t;

endpackage
`default_nettype wire

// ===== hdl/neighbor_link_quality_table_core.sv =====
// Top level of the neighbour link quality table: ring of cells and sequencer.
`default_nettype none
// Every command rotates the whole ring of TABLE_DEPTH cells once past the head,
// one entry per clock, and busy stays high while it does. A touch or update of an
// absent link that finds room then keeps rotating, with busy still high, until the
// first free entry reaches the head, where the new link is written.
// The result appears on done in the first cycle in which busy is low again and is
// held for that single cycle only, so the receiver must take it then; a new command
// may be started in that same cycle. Configuration writes are only expected while
// busy is low. After reset the table is empty and ready at once.
module neighbor_link_quality_table_core
    import nlqt_pkg::*;
#(
    parameter int TABLE_DEPTH   = 64,
    parameter int WAVEFORM_BITS = 4
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [2:0]               command,
    input  wire logic [NODE_W-1:0]        node_key,
    input  wire logic [WAVEFORM_BITS-1:0] waveform_key,
    input  wire logic [Q_W-1:0]           new_quality,
    input  wire logic                     count_all_waveforms,
    output logic                          done,
    output logic [1:0]                    status,
    output logic                          found,
    output logic [Q_W-1:0]                quality_out,
    output logic [COUNT_W-1:0]            good_count,
    input  wire logic                     write_enable,
    input  wire logic [CFG_IDX_W-1:0]     write_index,
    input  wire logic [Q_W-1:0]           write_data
);

    localparam int CNT_W = $clog2(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(TABLE_DEPTH - 1);

    // Configuration
    logic [Q_W-1:0] touch_step_reg;
    logic [Q_W-1:0] ceiling_reg;

    // Sequencer
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  pos_reg;
    logic              shift_en;
    logic              accept;
    logic              last_pos;

    // Latched command
    cmd_t                     cmd_reg;
    logic [NODE_W-1:0]        node_reg;
    logic [WAVEFORM_BITS-1:0] wf_reg;
    logic [Q_W-1:0]           newq_reg;
    logic                     all_reg;

    // Scan accumulators
    logic               found_reg;
    logic               free_seen_reg;
    logic [Q_W-1:0]     qhit_reg;
    logic [COUNT_W-1:0] count_reg;

    logic               found_fin;
    logic               free_fin;
    logic [Q_W-1:0]     qhit_fin;
    logic [COUNT_W-1:0] count_fin;
    logic               is_insert_cmd;
    logic               need_insert;
    logic               scan_end;
    logic               insert_end;

    // Result registers
    logic               done_reg;
    status_t            status_reg;
    logic               found_out_reg;
    logic [Q_W-1:0]     qout_reg;
    logic [COUNT_W-1:0] gcount_reg;

    // Ring
    logic                     ring_valid [TABLE_DEPTH];
    logic [NODE_W-1:0]        ring_node  [TABLE_DEPTH];
    logic [WAVEFORM_BITS-1:0] ring_wf    [TABLE_DEPTH];
    logic [Q_W-1:0]           ring_q     [TABLE_DEPTH];

    logic                     head_valid;
    logic [NODE_W-1:0]        head_node;
    logic [WAVEFORM_BITS-1:0] head_wf;
    logic [Q_W-1:0]           head_q;
    logic [Q_W-1:0]           q_after;
    hd_flags_t                flags;
    hd_ctrl_t                 ctrl;

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            touch_step_reg <= TOUCH_STEP_RESET;
            ceiling_reg    <= CEILING_RESET;
        end
        else if (write_enable)
        begin
            case (reg_idx_t'(write_index))
                REG_TOUCH_STEP: touch_step_reg <= write_data;
                REG_CEILING:    ceiling_reg    <= write_data;
                default:        ;
            endcase
        end
    end

    // Chain the cells, closing the ring through the head
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic                     c_valid;
        logic [NODE_W-1:0]        c_node;
        logic [WAVEFORM_BITS-1:0] c_wf;
        logic [Q_W-1:0]           c_q;

        if (i == 0)
        begin : g_first
            assign c_valid = head_valid;
            assign c_node  = head_node;
            assign c_wf    = head_wf;
            assign c_q     = head_q;
        end
        else
        begin : g_rest
            assign c_valid = ring_valid[i-1];
            assign c_node  = ring_node[i-1];
            assign c_wf    = ring_wf[i-1];
            assign c_q     = ring_q[i-1];
        end

        nlqt_cell #(
            .WAVEFORM_BITS(WAVEFORM_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (shift_en),
            .in_valid (c_valid),
            .in_node  (c_node),
            .in_wf    (c_wf),
            .in_q     (c_q),
            .out_valid(ring_valid[i]),
            .out_node (ring_node[i]),
            .out_wf   (ring_wf[i]),
            .out_q    (ring_q[i])
        );
    end

    assign ctrl.cmd         = cmd_reg;
    assign ctrl.insert_mode = (state_reg == ST_INSERT);
    assign ctrl.count_all   = all_reg;

    nlqt_head #(
        .WAVEFORM_BITS(WAVEFORM_BITS)
    ) u_head (
        .ctrl           (ctrl),
        .key_node       (node_reg),
        .key_wf         (wf_reg),
        .new_quality    (newq_reg),
        .touch_step     (touch_step_reg),
        .quality_ceiling(ceiling_reg),
        .in_valid       (ring_valid[TABLE_DEPTH-1]),
        .in_node        (ring_node[TABLE_DEPTH-1]),
        .in_wf          (ring_wf[TABLE_DEPTH-1]),
        .in_q           (ring_q[TABLE_DEPTH-1]),
        .out_valid      (head_valid),
        .out_node       (head_node),
        .out_wf         (head_wf),
        .out_q          (head_q),
        .q_after        (q_after),
        .flags          (flags)
    );

    // Fold the current head observation into the scan totals
    assign found_fin     = found_reg | flags.match;
    assign free_fin      = free_seen_reg | flags.free;
    assign qhit_fin      = flags.match ? q_after : qhit_reg;
    assign count_fin     = (flags.count_hit && (count_reg != COUNT_MAX)) ?
                           count_reg + COUNT_W'(1) : count_reg;
    assign is_insert_cmd = (cmd_reg == CMD_TOUCH) || (cmd_reg == CMD_UPDATE);
    assign need_insert   = is_insert_cmd && !found_fin && free_fin;
    assign last_pos      = (pos_reg == LAST_POS);
    assign accept        = start && !busy;
    assign scan_end      = (state_reg == ST_SCAN) && last_pos && !need_insert;
    assign insert_end    = (state_reg == ST_INSERT) && flags.insert_hit;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last_pos)
                begin
                    state_next = need_insert ? ST_INSERT : ST_IDLE;
                end
            end
            ST_INSERT:
            begin
                if (flags.insert_hit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        case (state_reg)
            ST_SCAN:
            begin
                busy     = 1'b1;
                shift_en = 1'b1;
            end
            ST_INSERT:
            begin
                busy     = 1'b1;
                shift_en = 1'b1;
            end
            default:
            begin
                busy     = 1'b0;
                shift_en = 1'b0;
            end
        endcase
    end

    // Advance state, ring position and scan totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            found_reg     <= 1'b0;
            free_seen_reg <= 1'b0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= scan_end || insert_end;
            if (accept)
            begin
                pos_reg       <= '0;
                found_reg     <= 1'b0;
                free_seen_reg <= 1'b0;
                count_reg     <= '0;
            end
            else if (state_reg == ST_SCAN)
            begin
                pos_reg       <= pos_reg + CNT_W'(1);
                found_reg     <= found_fin;
                free_seen_reg <= free_fin;
                count_reg     <= count_fin;
            end
        end
    end

    // Latch the command transaction and the matched quality
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd_t'(command);
            node_reg <= node_key;
            wf_reg   <= waveform_key;
            newq_reg <= new_quality;
            all_reg  <= count_all_waveforms;
        end
        if (state_reg == ST_SCAN)
        begin
            qhit_reg <= qhit_fin;
        end
    end

    // Form the result transaction
    always_ff @(posedge clk)
    begin
        if (scan_end)
        begin
            found_out_reg <= found_fin;
            case (cmd_reg)
                CMD_TOUCH, CMD_UPDATE:
                begin
                    status_reg <= found_fin ? STATUS_DONE : STATUS_FULL;
                    qout_reg   <= found_fin ? qhit_fin : '0;
                    gcount_reg <= '0;
                end
                CMD_REMOVE:
                begin
                    status_reg <= found_fin ? STATUS_DONE : STATUS_NOT_FOUND;
                    qout_reg   <= '0;
                    gcount_reg <= '0;
                end
                CMD_LOOKUP:
                begin
                    status_reg <= found_fin ? STATUS_DONE : STATUS_NOT_FOUND;
                    qout_reg   <= found_fin ? qhit_fin : '0;
                    gcount_reg <= '0;
                end
                CMD_COUNT:
                begin
                    status_reg <= STATUS_DONE;
                    qout_reg   <= '0;
                    gcount_reg <= count_fin;
                end
                default:
                begin
                    status_reg <= STATUS_DONE;
                    qout_reg   <= '0;
                    gcount_reg <= '0;
                end
            endcase
        end
        else if (insert_end)
        begin
            status_reg    <= STATUS_DONE;
            found_out_reg <= 1'b0;
            qout_reg      <= head_q;
            gcount_reg    <= '0;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign found       = found_out_reg;
    assign quality_out = qout_reg;
    assign good_count  = gcount_reg;

    // A result is only delivered once the sequencer is back at rest
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // An accepted command always starts a full scan
    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == ST_SCAN))
        else $error("accepted command did not start a scan");

    // The insert pass only runs when the scan saw a free entry
    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INSERT) |-> free_seen_reg)
        else $error("insert pass without a free entry");

    // A dropped insert reports no link
    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STATUS_FULL)) |-> (!found && (quality_out == '0)))
        else $error("dropped insert reported a link");

    // A link count comes only with a plain completion
    a_count_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (good_count != '0)) |-> ((status == STATUS_DONE) && !found))
        else $error("count mixed with a keyed result");

endmodule
`default_nettype wire

// ===== hdl/nlqt_cell.sv =====
// One table entry of the rotating ring: holds a link and passes it on.
`default_nettype none
module nlqt_cell
    import nlqt_pkg::*;
#(
    parameter int WAVEFORM_BITS = 4
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     shift_en,
    input  wire logic                     in_valid,
    input  wire logic [NODE_W-1:0]        in_node,
    input  wire logic [WAVEFORM_BITS-1:0] in_wf,
    input  wire logic [Q_W-1:0]           in_q,
    output logic                          out_valid,
    output logic [NODE_W-1:0]             out_node,
    output logic [WAVEFORM_BITS-1:0]      out_wf,
    output logic [Q_W-1:0]                out_q
);

    logic                     valid_reg;
    logic [NODE_W-1:0]        node_reg;
    logic [WAVEFORM_BITS-1:0] wf_reg;
    logic [Q_W-1:0]           q_reg;

    // Hold the valid flag; only it is cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift_en)
        begin
            valid_reg <= in_valid;
        end
    end

    // Advance the link payload
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            node_reg <= in_node;
            wf_reg   <= in_wf;
            q_reg    <= in_q;
        end
    end

    assign out_valid = valid_reg;
    assign out_node  = node_reg;
    assign out_wf    = wf_reg;
    assign out_q     = q_reg;

endmodule
`default_nettype wire

// ===== hdl/nlqt_head.sv =====
// Ring head: examines the entry passing by and rewrites it for the command.
`default_nettype none
module nlqt_head
    import nlqt_pkg::*;
#(
    parameter int WAVEFORM_BITS = 4
)
(
    input  wire hd_ctrl_t                 ctrl,
    input  wire logic [NODE_W-1:0]        key_node,
    input  wire logic [WAVEFORM_BITS-1:0] key_wf,
    input  wire logic [Q_W-1:0]           new_quality,
    input  wire logic [Q_W-1:0]           touch_step,
    input  wire logic [Q_W-1:0]           quality_ceiling,
    input  wire logic                     in_valid,
    input  wire logic [NODE_W-1:0]        in_node,
    input  wire logic [WAVEFORM_BITS-1:0] in_wf,
    input  wire logic [Q_W-1:0]           in_q,
    output logic                          out_valid,
    output logic [NODE_W-1:0]             out_node,
    output logic [WAVEFORM_BITS-1:0]      out_wf,
    output logic [Q_W-1:0]                out_q,
    output logic [Q_W-1:0]                q_after,
    output hd_flags_t                     flags
);

    logic         key_hit;
    logic         cmd_keyed;
    logic [Q_W:0] sum;
    logic [Q_W-1:0] sat_q;
    logic [Q_W-1:0] ins_q;

    // Compare the passing entry with the key
    assign key_hit   = in_valid && (in_node == key_node) && (in_wf == key_wf);
    assign cmd_keyed = (ctrl.cmd == CMD_TOUCH) || (ctrl.cmd == CMD_UPDATE) ||
                       (ctrl.cmd == CMD_REMOVE) || (ctrl.cmd == CMD_LOOKUP);

    // Saturate the touched quality at the ceiling
    assign sum   = {1'b0, in_q} + {1'b0, touch_step};
    assign sat_q = (sum > {1'b0, quality_ceiling}) ? quality_ceiling : sum[Q_W-1:0];
    assign ins_q = (ctrl.cmd == CMD_TOUCH) ? touch_step : new_quality;

    always_comb
    begin
        flags.match      = !ctrl.insert_mode && cmd_keyed && key_hit;
        flags.free       = !in_valid;
        flags.count_hit  = !ctrl.insert_mode && (ctrl.cmd == CMD_COUNT) && in_valid &&
                           (in_q != '0) && (ctrl.count_all || (in_wf == key_wf));
        flags.insert_hit = ctrl.insert_mode && !in_valid;
    end

    // Quality of the matched entry after the command
    always_comb
    begin
        case (ctrl.cmd)
            CMD_TOUCH:  q_after = sat_q;
            CMD_UPDATE: q_after = new_quality;
            default:    q_after = in_q;
        endcase
    end

    // Rewrite the entry on a match or drop the new link into a free slot
    always_comb
    begin
        out_valid = in_valid;
        out_node  = in_node;
        out_wf    = in_wf;
        out_q     = in_q;
        if (flags.match)
        begin
            out_q = q_after;
            if (ctrl.cmd == CMD_REMOVE)
            begin
                out_valid = 1'b0;
            end
        end
        else if (flags.insert_hit)
        begin
            out_valid = 1'b1;
            out_node  = key_node;
            out_wf    = key_wf;
            out_q     = ins_q;
        end
    end

endmodule
`default_nettype wire

// ===== dv/nlqt_link_checker.sv =====
// Checker for the neighbour link quality table: predicts each transaction and compares.
module nlqt_link_checker
    import nlqt_pkg::*;
#(
    parameter int TABLE_DEPTH   = 64,
    parameter int WAVEFORM_BITS = 4
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic                     busy,
    input  wire logic [2:0]               command,
    input  wire logic [NODE_W-1:0]        node_key,
    input  wire logic [WAVEFORM_BITS-1:0] waveform_key,
    input  wire logic [Q_W-1:0]           new_quality,
    input  wire logic                     count_all_waveforms,
    input  wire logic                     done,
    input  wire logic [1:0]               status,
    input  wire logic                     found,
    input  wire logic [Q_W-1:0]           quality_out,
    input  wire logic [COUNT_W-1:0]       good_count,
    input  wire logic                     write_enable,
    input  wire logic [CFG_IDX_W-1:0]     write_index,
    input  wire logic [Q_W-1:0]           write_data,
    output int                            failures,
    output int                            answers_pending,
    output int                            answers_checked,
    output int                            full_drops
);

    typedef struct {
        status_t            status;
        logic               found;
        logic [Q_W-1:0]     quality;
        logic [COUNT_W-1:0] good;
    } link_answer_t;

    link_answer_t answers_due[$];

    // Shadow copy of the registers and of the table
    logic [Q_W-1:0]           step_reg;
    logic [Q_W-1:0]           ceiling_reg;
    logic                     link_valid   [TABLE_DEPTH];
    logic [NODE_W-1:0]        link_node    [TABLE_DEPTH];
    logic [WAVEFORM_BITS-1:0] link_wave    [TABLE_DEPTH];
    logic [Q_W-1:0]           link_quality [TABLE_DEPTH];

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
        failures++;
    endtask

    function automatic int find_link(input logic [NODE_W-1:0] node,
                                     input logic [WAVEFORM_BITS-1:0] wave);
        int i;
        for (i = 0; i < TABLE_DEPTH; i++)
        begin
            if (link_valid[i] && link_node[i] == node && link_wave[i] == wave)
                return i;
        end
        return -1;
    endfunction

    // Place a new link in the lowest free slot; report whether there was room
    function automatic bit insert_link(input logic [NODE_W-1:0] node,
                                       input logic [WAVEFORM_BITS-1:0] wave,
                                       input logic [Q_W-1:0] quality);
        int i;
        for (i = 0; i < TABLE_DEPTH; i++)
        begin
            if (!link_valid[i])
            begin
                link_valid[i]   = 1'b1;
                link_node[i]    = node;
                link_wave[i]    = wave;
                link_quality[i] = quality;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Apply one command to the shadow table and return its answer
    function automatic link_answer_t apply_command(input logic [2:0] op,
                                                   input logic [NODE_W-1:0] node,
                                                   input logic [WAVEFORM_BITS-1:0] wave,
                                                   input logic [Q_W-1:0] quality_in,
                                                   input logic all_waves);
        link_answer_t ans;
        int           hit;
        int           i;
        logic [Q_W:0] raised;
        ans.status  = STATUS_DONE;
        ans.found   = 1'b0;
        ans.quality = '0;
        ans.good    = '0;
        hit = find_link(node, wave);
        case (op)
            CMD_TOUCH:
            begin
                ans.found = (hit >= 0);
                if (hit >= 0)
                begin
                    // Saturate the exact sum at the ceiling
                    raised = {1'b0, link_quality[hit]} + {1'b0, step_reg};
                    if (raised > {1'b0, ceiling_reg})
                        raised = {1'b0, ceiling_reg};
                    link_quality[hit] = raised[Q_W-1:0];
                    ans.quality       = raised[Q_W-1:0];
                end
                else if (insert_link(node, wave, step_reg))
                    ans.quality = step_reg;
                else
                    ans.status = STATUS_FULL;
            end
            CMD_UPDATE:
            begin
                ans.found = (hit >= 0);
                if (hit >= 0)
                begin
                    link_quality[hit] = quality_in;
                    ans.quality       = quality_in;
                end
                else if (insert_link(node, wave, quality_in))
                    ans.quality = quality_in;
                else
                    ans.status = STATUS_FULL;
            end
            CMD_REMOVE:
            begin
                ans.found = (hit >= 0);
                if (hit >= 0)
                    link_valid[hit] = 1'b0;
                else
                    ans.status = STATUS_NOT_FOUND;
            end
            CMD_LOOKUP:
            begin
                ans.found = (hit >= 0);
                if (hit >= 0)
                    ans.quality = link_quality[hit];
                else
                    ans.status = STATUS_NOT_FOUND;
            end
            CMD_COUNT:
            begin
                for (i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (link_valid[i] && link_quality[i] != '0 &&
                        (all_waves || link_wave[i] == wave) && ans.good != COUNT_MAX)
                        ans.good = ans.good + COUNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        link_answer_t due;
        int           i;
        if (!rst_n)
        begin
            step_reg    = TOUCH_STEP_RESET;
            ceiling_reg = CEILING_RESET;
            for (i = 0; i < TABLE_DEPTH; i++)
            begin
                link_valid[i]   = 1'b0;
                link_node[i]    = '0;
                link_wave[i]    = '0;
                link_quality[i] = '0;
            end
            answers_due.delete();
            failures        = 0;
            answers_pending = 0;
            answers_checked = 0;
            full_drops      = 0;
        end
        else
        begin
            // Compare a finished transaction with the oldest prediction
            if (done)
            begin
                if (answers_due.size() == 0)
                    report_mismatch("done with no command outstanding", 16'd1, 16'd0);
                else
                begin
                    due = answers_due.pop_front();
                    answers_checked++;
                    if (due.status == STATUS_FULL)
                        full_drops++;
                    if (status !== due.status)
                        report_mismatch("status", 16'(status), 16'(due.status));
                    if (found !== due.found)
                        report_mismatch("found", 16'(found), 16'(due.found));
                    if (quality_out !== due.quality)
                        report_mismatch("quality_out", 16'(quality_out),
                                        16'(due.quality));
                    if (good_count !== due.good)
                        report_mismatch("good_count", 16'(good_count), 16'(due.good));
                end
            end
            // Track register writes
            if (write_enable)
            begin
                if (write_index == REG_TOUCH_STEP)
                    step_reg = write_data;
                else if (write_index == REG_CEILING)
                    ceiling_reg = write_data;
            end
            // Predict an accepted command
            if (start && !busy)
                answers_due.push_back(apply_command(command, node_key, waveform_key,
                                                    new_quality, count_all_waveforms));
            answers_pending = answers_due.size();
        end
    end

endmodule

// ===== dv/tb_neighbor_link_quality_table_core.sv =====
// Stimulus and verdict for the neighbour link quality table core.
module tb_neighbor_link_quality_table_core;
    import nlqt_pkg::*;

    localparam int TABLE_DEPTH   = 64;
    localparam int WAVEFORM_BITS = 4;
    localparam int POOL_MAX      = 96;
    localparam int PHASE_ITEMS   = 155;
    localparam int DRAIN_CYCLES  = 2 * TABLE_DEPTH + 8;

    // Command codes the block leaves unused
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    typedef enum int {
        TRAFFIC_MIX,
        TRAFFIC_FILL,
        TRAFFIC_DRAIN
    } traffic_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [2:0]               command;
    logic [NODE_W-1:0]        node_key;
    logic [WAVEFORM_BITS-1:0] waveform_key;
    logic [Q_W-1:0]           new_quality;
    logic                     count_all_waveforms;
    logic                     done;
    logic [1:0]               status;
    logic                     found;
    logic [Q_W-1:0]           quality_out;
    logic [COUNT_W-1:0]       good_count;
    logic                     write_enable;
    logic [CFG_IDX_W-1:0]     write_index;
    logic [Q_W-1:0]           write_data;

    int failures;
    int answers_pending;
    int answers_checked;
    int full_drops;
    int commands_sent;
    int settings_used;

    logic [NODE_W-1:0]        pool_node [POOL_MAX];
    logic [WAVEFORM_BITS-1:0] pool_wave [POOL_MAX];

    neighbor_link_quality_table_core #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .WAVEFORM_BITS (WAVEFORM_BITS)
    ) dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .busy                (busy),
        .command             (command),
        .node_key            (node_key),
        .waveform_key        (waveform_key),
        .new_quality         (new_quality),
        .count_all_waveforms (count_all_waveforms),
        .done                (done),
        .status              (status),
        .found               (found),
        .quality_out         (quality_out),
        .good_count          (good_count),
        .write_enable        (write_enable),
        .write_index         (write_index),
        .write_data          (write_data)
    );

    nlqt_link_checker #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .WAVEFORM_BITS (WAVEFORM_BITS)
    ) link_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .busy                (busy),
        .command             (command),
        .node_key            (node_key),
        .waveform_key        (waveform_key),
        .new_quality         (new_quality),
        .count_all_waveforms (count_all_waveforms),
        .done                (done),
        .status              (status),
        .found               (found),
        .quality_out         (quality_out),
        .good_count          (good_count),
        .write_enable        (write_enable),
        .write_index         (write_index),
        .write_data          (write_data),
        .failures            (failures),
        .answers_pending     (answers_pending),
        .answers_checked     (answers_checked),
        .full_drops          (full_drops)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Give up on a hung run
    initial
    begin
        #8_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Offer one command; returns at the falling edge after it is taken
    task automatic issue_command(input logic [2:0] op, input logic [NODE_W-1:0] node,
                                 input logic [WAVEFORM_BITS-1:0] wave,
                                 input logic [Q_W-1:0] quality_in, input logic all_waves,
                                 input int gap);
        if (gap > 0)
        begin
            start = 1'b0;
            while (busy)
                @(negedge clk);
            repeat (gap) @(negedge clk);
        end
        command             = op;
        node_key            = node;
        waveform_key        = wave;
        new_quality         = quality_in;
        count_all_waveforms = all_waves;
        start               = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        commands_sent++;
    endtask

    // Hold off until every answer is back and the block is free
    task automatic wait_idle();
        start = 1'b0;
        while (answers_pending != 0 || busy)
            @(negedge clk);
    endtask

    task automatic write_register(input reg_idx_t idx, input logic [Q_W-1:0] value);
        write_enable = 1'b1;
        write_index  = idx;
        write_data   = value;
        @(negedge clk);
        write_enable = 1'b0;
        write_data   = 10'($urandom);
    endtask

    task automatic set_registers(input logic [Q_W-1:0] step, input logic [Q_W-1:0] ceiling);
        wait_idle();
        write_register(REG_TOUCH_STEP, step);
        write_register(REG_CEILING, ceiling);
        settings_used++;
    endtask

    // One phase of random traffic over a fresh pool of link keys
    task automatic run_phase(input logic [Q_W-1:0] step, input logic [Q_W-1:0] ceiling,
                             input int pool_size, input traffic_t traffic);
        int               n;
        int               pick;
        int               roll;
        int               gap;
        logic [2:0]       op;
        logic [NODE_W-1:0]        node;
        logic [WAVEFORM_BITS-1:0] wave;
        logic [Q_W-1:0]   quality_in;
        set_registers(step, ceiling);
        for (n = 0; n < pool_size; n++)
        begin
            pool_node[n] = 16'($urandom);
            pool_wave[n] = 4'($urandom);
        end
        pool_node[0] = '0;
        pool_node[1] = '1;
        pool_wave[1] = '1;
        for (n = 0; n < PHASE_ITEMS; n++)
        begin
            // Choose the command according to the phase's traffic shape
            roll = $urandom_range(99, 0);
            case (traffic)
                TRAFFIC_FILL:
                    op = roll < 45 ? CMD_TOUCH : roll < 85 ? CMD_UPDATE :
                         roll < 90 ? CMD_REMOVE : roll < 95 ? CMD_LOOKUP :
                         roll < 98 ? CMD_COUNT : 3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
                TRAFFIC_DRAIN:
                    op = roll < 10 ? CMD_TOUCH : roll < 20 ? CMD_UPDATE :
                         roll < 65 ? CMD_REMOVE : roll < 85 ? CMD_LOOKUP :
                         roll < 95 ? CMD_COUNT : 3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
                default:
                    op = roll < 30 ? CMD_TOUCH : roll < 55 ? CMD_UPDATE :
                         roll < 70 ? CMD_REMOVE : roll < 85 ? CMD_LOOKUP :
                         roll < 95 ? CMD_COUNT : 3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
            endcase
            // Mostly pooled keys so links recur, now and then a stray one
            if ($urandom_range(7, 0) == 0)
            begin
                node = 16'($urandom);
                wave = 4'($urandom);
            end
            else
            begin
                pick = $urandom_range(pool_size - 1, 0);
                node = pool_node[pick];
                wave = pool_wave[pick];
            end
            case ($urandom_range(9, 0))
                0:       quality_in = '0;
                1:       quality_in = 10'($urandom);
                2:       quality_in = 10'd1000;
                default: quality_in = 10'($urandom_range(1000, 0));
            endcase
            // Leave a stretch of back-to-back commands in every phase
            gap = (n % 50) < 12 ? 0 : $urandom_range(9, 0);
            issue_command(op, node, wave, quality_in, 1'($urandom), gap);
        end
    endtask

    initial
    begin
        rst_n               = 1'b0;
        start               = 1'b0;
        command             = CMD_LOOKUP;
        node_key            = '0;
        waveform_key        = '0;
        new_quality         = '0;
        count_all_waveforms = 1'b0;
        write_enable        = 1'b0;
        write_index         = REG_TOUCH_STEP;
        write_data          = '0;
        commands_sent       = 0;
        settings_used       = 1;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty table, extremes, saturation and unused codes
        issue_command(CMD_LOOKUP, 16'h0000, 4'h0, 10'h3FF, 1'b1, 0);
        issue_command(CMD_REMOVE, 16'h0000, 4'h0, 10'h000, 1'b0, 3);
        issue_command(CMD_COUNT,  16'hFFFF, 4'h0, 10'h155, 1'b0, 0);
        issue_command(CMD_TOUCH,  16'hFFFF, 4'hF, 10'h2AA, 1'b1, 1);
        issue_command(CMD_TOUCH,  16'hFFFF, 4'hF, 10'h000, 1'b0, 0);
        issue_command(CMD_UPDATE, 16'h0000, 4'h0, 10'd1000, 1'b1, 9);
        issue_command(CMD_UPDATE, 16'h0000, 4'h0, 10'h3FF, 1'b0, 0);
        issue_command(CMD_TOUCH,  16'h0000, 4'h0, 10'h000, 1'b0, 2);
        issue_command(CMD_UPDATE, 16'h0001, 4'h0, 10'h000, 1'b1, 0);
        issue_command(CMD_COUNT,  16'h1234, 4'h0, 10'h3FF, 1'b0, 0);
        issue_command(CMD_COUNT,  16'h0000, 4'hF, 10'h000, 1'b1, 5);
        issue_command(CMD_LOOKUP, 16'hFFFF, 4'hF, 10'h000, 1'b0, 0);
        issue_command(CMD_TOUCH,  16'h0000, 4'hF, 10'h3FF, 1'b0, 0);
        issue_command(CMD_REMOVE, 16'hFFFF, 4'hF, 10'h000, 1'b1, 4);
        issue_command(CMD_LOOKUP, 16'hFFFF, 4'hF, 10'h000, 1'b0, 0);
        issue_command(CMD_SPARE_LO, 16'h0000, 4'h0, 10'd500, 1'b1, 0);
        issue_command(CMD_SPARE_HI, 16'hFFFF, 4'hF, 10'h3FF, 1'b1, 7);

        // Zero step and zero ceiling: touches pull everything to zero
        set_registers(10'd0, 10'd0);
        issue_command(CMD_TOUCH,  16'h0000, 4'h0, 10'h000, 1'b0, 0);
        issue_command(CMD_TOUCH,  16'h0002, 4'h3, 10'h000, 1'b0, 1);

        // Full step over a zero ceiling: an inserted link keeps the step
        set_registers(10'd1000, 10'd0);
        issue_command(CMD_TOUCH,  16'h0004, 4'h5, 10'h000, 1'b0, 0);
        issue_command(CMD_TOUCH,  16'h0004, 4'h5, 10'h000, 1'b0, 0);
        issue_command(CMD_COUNT,  16'h0000, 4'h0, 10'h000, 1'b1, 6);

        // Random phases over several register settings
        run_phase(10'd100,  10'd1000, 12, TRAFFIC_MIX);
        run_phase(10'd0,    10'd1000, 96, TRAFFIC_FILL);
        run_phase(10'd1000, 10'd1000, 96, TRAFFIC_FILL);
        run_phase(10'd1000, 10'd0,    40, TRAFFIC_MIX);
        run_phase(10'd7,    10'd999,  96, TRAFFIC_DRAIN);
        run_phase(10'($urandom_range(1000, 0)), 10'($urandom_range(1000, 0)), 20,
                  TRAFFIC_MIX);
        run_phase(10'd250,  10'd600,  64, TRAFFIC_FILL);

        // Drain outstanding answers and let the block settle
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d commands under %0d register settings.", commands_sent,
                 settings_used);
        $display("Checked %0d answers, %0d of them inserts refused by a full table.",
                 answers_checked, full_drops);
        if (failures == 0 && answers_pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/nlqt_pkg.sv
hdl/nlqt_cell.sv
hdl/nlqt_head.sv
hdl/neighbor_link_quality_table_core.sv
dv/nlqt_link_checker.sv
dv/tb_neighbor_link_quality_table_core.sv
